>>> rtl/pwm_duty_frequency_meter_defines.svh
`ifndef PWM_DUTY_FREQUENCY_METER_DEFINES_SVH
`define PWM_DUTY_FREQUENCY_METER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PDFM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PDFM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pdfm_pkg.sv
`timescale 1ns / 1ps

package pdfm_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_BITS   = 24;

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LEVEL_W   = 4;
    localparam int LVL_EXT_W = (NUM_CHANNELS > LEVEL_W) ? NUM_CHANNELS : LEVEL_W;
    localparam int RC_W      = 3;

    localparam int PERIOD_W = COUNT_BITS + 1;
    localparam int DEN_W    = COUNT_BITS + 2;
    localparam int DUTY_W   = 7;
    localparam int FREQ_W   = 10;
    localparam int QUOT_W   = FREQ_W;
    localparam int REM_W    = DEN_W + QUOT_W;
    localparam int STEP_W   = 4;

    localparam int DUTY_SCALE = 200;
    localparam int FREQ_NUM   = 2000;
    localparam int DUTY_MAX   = 100;
    localparam int FREQ_MAX   = 1000;

    localparam logic [STEP_W-1:0] DUTY_STEPS = STEP_W'(DUTY_W);
    localparam logic [STEP_W-1:0] FREQ_STEPS = STEP_W'(FREQ_W);

    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic              capture;
        logic              step;
        logic              prep_duty;
        logic              prep_freq;
        logic              div_start;
        logic [STEP_W-1:0] div_steps;
        logic              save_duty;
        logic              commit;
        logic              out_load;
        logic [CH_W-1:0]   chan;
    } cmd_t;

    typedef struct packed {
        logic need;
        logic div_busy;
    } status_t;

endpackage

>>> rtl/pdfm_divider.sv
`timescale 1ns / 1ps

module pdfm_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [pdfm_pkg::STEP_W-1:0]          steps,
    input  logic [pdfm_pkg::REM_W-1:0]           num,
    input  logic [pdfm_pkg::DEN_W-1:0]           den,
    output logic                                 busy,
    output logic [pdfm_pkg::QUOT_W-1:0]          quot
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [pdfm_pkg::STEP_W-1:0]   cnt_reg;
    logic [pdfm_pkg::STEP_W-1:0]   cnt_next;
    logic [pdfm_pkg::REM_W-1:0]    rem_reg;
    logic [pdfm_pkg::REM_W-1:0]    rem_next;
    logic [pdfm_pkg::REM_W-1:0]    dsh_reg;
    logic [pdfm_pkg::REM_W-1:0]    dsh_next;
    logic [pdfm_pkg::QUOT_W-1:0]   quot_reg;
    logic [pdfm_pkg::QUOT_W-1:0]   quot_next;
    logic                          fits;

    // The quotient is known to fit in the given number of steps, so the
    // divisor starts aligned to the top quotient bit and moves down one a cycle.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        fits      = (rem_reg >= dsh_reg);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = num;
            dsh_next  = pdfm_pkg::REM_W'(den) << (steps - 1'b1);
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[pdfm_pkg::QUOT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == pdfm_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

>>> rtl/pdfm_datapath.sv
`timescale 1ns / 1ps
`include "pwm_duty_frequency_meter_defines.svh"

module pdfm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_op,
    input  logic [pdfm_pkg::LEVEL_W-1:0]      in_levels,
    input  logic [pdfm_pkg::RC_W-1:0]         in_read_channel,
    input  pdfm_pkg::cmd_t                    cmd,
    output pdfm_pkg::status_t                 stat,
    output logic                              glitch_seen,
    output logic                              channel_ok,
    output logic [pdfm_pkg::DUTY_W-1:0]       duty,
    output logic [pdfm_pkg::FREQ_W-1:0]       frequency
);

    localparam int N = pdfm_pkg::NUM_CHANNELS;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_RISE      = 3'd1;
    localparam logic [2:0] PH_HIGH_WAIT = 3'd2;
    localparam logic [2:0] PH_FALL      = 3'd3;
    localparam logic [2:0] PH_LOW_WAIT  = 3'd4;
    localparam logic [2:0] PH_FINISH    = 3'd5;

    logic                               op_reg;
    logic [pdfm_pkg::LEVEL_W-1:0]       levels_reg;
    logic [pdfm_pkg::RC_W-1:0]          rc_reg;

    logic [2:0]                         phase_reg [N];
    logic [2:0]                         phase_next [N];
    pdfm_pkg::count_t                   tick_reg [N];
    pdfm_pkg::count_t                   tick_next [N];
    pdfm_pkg::count_t                   high_reg [N];
    pdfm_pkg::count_t                   high_next [N];
    logic [pdfm_pkg::DUTY_W-1:0]        duty_store_reg [N];
    logic [pdfm_pkg::DUTY_W-1:0]        duty_store_next [N];
    logic [pdfm_pkg::FREQ_W-1:0]        freq_store_reg [N];
    logic [pdfm_pkg::FREQ_W-1:0]        freq_store_next [N];
    logic [N-1:0]                       fin_reg;
    logic [N-1:0]                       fin_next;
    logic                               glitch_reg;
    logic                               glitch_next;

    logic [pdfm_pkg::REM_W-1:0]         num_reg;
    logic [pdfm_pkg::DEN_W-1:0]         den_reg;
    logic [pdfm_pkg::DUTY_W-1:0]        duty_tmp_reg;

    logic                               glitch_out_reg;
    logic                               ok_out_reg;
    logic [pdfm_pkg::DUTY_W-1:0]        duty_out_reg;
    logic [pdfm_pkg::FREQ_W-1:0]        freq_out_reg;

    logic [pdfm_pkg::LVL_EXT_W-1:0]     levels_ext;
    pdfm_pkg::count_t                   hi_sel;
    pdfm_pkg::count_t                   lo_sel;
    logic [pdfm_pkg::PERIOD_W-1:0]      period;
    logic                               rc_ok;
    logic [pdfm_pkg::CH_W-1:0]          rc_idx;
    logic                               div_busy;
    logic [pdfm_pkg::QUOT_W-1:0]        div_quot;

    assign levels_ext = pdfm_pkg::LVL_EXT_W'(levels_reg);

    // Every channel steps in parallel; finished periods are only marked here
    // and divided later, one channel at a time.
    always_comb
    begin
        glitch_next = glitch_reg;
        fin_next    = fin_reg;
        if (cmd.capture)
        begin
            glitch_next = 1'b0;
            fin_next    = '0;
        end
        for (int c = 0; c < N; c++)
        begin
            phase_next[c]      = phase_reg[c];
            tick_next[c]       = tick_reg[c];
            high_next[c]       = high_reg[c];
            duty_store_next[c] = duty_store_reg[c];
            freq_store_next[c] = freq_store_reg[c];
            if (cmd.step)
            begin
                if (!op_reg)
                begin
                    if (tick_reg[c] != pdfm_pkg::COUNT_MAX)
                    begin
                        tick_next[c] = tick_reg[c] + 1'b1;
                    end
                end
                else
                begin
                    unique case (phase_reg[c])
                        PH_RISE:
                        begin
                            tick_next[c] = '0;
                            if (levels_ext[c])
                            begin
                                phase_next[c] = PH_HIGH_WAIT;
                            end
                            else
                            begin
                                phase_next[c] = PH_IDLE;
                                glitch_next   = 1'b1;
                            end
                        end
                        PH_HIGH_WAIT:
                        begin
                            if (!levels_ext[c])
                            begin
                                phase_next[c] = PH_FALL;
                            end
                        end
                        PH_FALL:
                        begin
                            high_next[c] = tick_reg[c];
                            tick_next[c] = '0;
                            if (!levels_ext[c])
                            begin
                                phase_next[c] = PH_LOW_WAIT;
                            end
                            else
                            begin
                                phase_next[c] = PH_IDLE;
                                glitch_next   = 1'b1;
                            end
                        end
                        PH_LOW_WAIT:
                        begin
                            if (levels_ext[c])
                            begin
                                phase_next[c] = PH_FINISH;
                            end
                        end
                        PH_FINISH:
                        begin
                            fin_next[c]   = 1'b1;
                            phase_next[c] = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next[c] = levels_ext[c] ? PH_RISE : PH_IDLE;
                        end
                    endcase
                end
            end
            if (cmd.commit && (cmd.chan == pdfm_pkg::CH_W'(c)))
            begin
                duty_store_next[c] = duty_tmp_reg;
                freq_store_next[c] = div_quot;
            end
        end
    end

    assign hi_sel = high_reg[cmd.chan];
    assign lo_sel = tick_reg[cmd.chan];
    assign period = pdfm_pkg::PERIOD_W'(hi_sel) + pdfm_pkg::PERIOD_W'(lo_sel);

    assign stat.need     = fin_reg[cmd.chan] && (period != '0);
    assign stat.div_busy = div_busy;

    assign rc_ok  = (32'(rc_reg) < 32'(N));
    assign rc_idx = rc_reg[pdfm_pkg::CH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < N; c++)
            begin
                phase_reg[c]      <= PH_IDLE;
                tick_reg[c]       <= '0;
                high_reg[c]       <= '0;
                duty_store_reg[c] <= '0;
                freq_store_reg[c] <= '0;
            end
            fin_reg    <= '0;
            glitch_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < N; c++)
            begin
                phase_reg[c]      <= phase_next[c];
                tick_reg[c]       <= tick_next[c];
                high_reg[c]       <= high_next[c];
                duty_store_reg[c] <= duty_store_next[c];
                freq_store_reg[c] <= freq_store_next[c];
            end
            fin_reg    <= fin_next;
            glitch_reg <= glitch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= in_op;
            levels_reg <= in_levels;
            rc_reg     <= in_read_channel;
        end
        if (cmd.prep_duty)
        begin
            num_reg <= pdfm_pkg::REM_W'(hi_sel) * pdfm_pkg::REM_W'(pdfm_pkg::DUTY_SCALE)
                     + pdfm_pkg::REM_W'(period);
            den_reg <= {period, 1'b0};
        end
        else if (cmd.prep_freq)
        begin
            num_reg <= pdfm_pkg::REM_W'(pdfm_pkg::FREQ_NUM) + pdfm_pkg::REM_W'(period);
        end
        if (cmd.save_duty)
        begin
            duty_tmp_reg <= div_quot[pdfm_pkg::DUTY_W-1:0];
        end
        if (cmd.out_load)
        begin
            glitch_out_reg <= glitch_reg;
            ok_out_reg     <= rc_ok;
            duty_out_reg   <= rc_ok ? duty_store_reg[rc_idx] : '0;
            freq_out_reg   <= rc_ok ? freq_store_reg[rc_idx] : '0;
        end
    end

    pdfm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .steps (cmd.div_steps),
        .num   (num_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign glitch_seen = glitch_out_reg;
    assign channel_ok  = ok_out_reg;
    assign duty        = duty_out_reg;
    assign frequency   = freq_out_reg;

    `PDFM_ASSERT_IMP(a_result_range, cmd.commit,
        (duty_tmp_reg <= pdfm_pkg::DUTY_W'(pdfm_pkg::DUTY_MAX)) &&
        (div_quot <= pdfm_pkg::QUOT_W'(pdfm_pkg::FREQ_MAX)),
        "stored duty or frequency out of range")
    `PDFM_ASSERT_NXT(a_tick_no_finish, cmd.step && !op_reg, fin_reg == '0,
        "a tick item marked a finished period")

endmodule

>>> rtl/pdfm_ctrl.sv
`timescale 1ns / 1ps
`include "pwm_duty_frequency_meter_defines.svh"

module pdfm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pdfm_pkg::status_t    stat,
    output pdfm_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_STEP      = 3'd1;
    localparam logic [2:0] S_SCAN      = 3'd2;
    localparam logic [2:0] S_DUTY_GO   = 3'd3;
    localparam logic [2:0] S_DUTY_WAIT = 3'd4;
    localparam logic [2:0] S_FREQ_GO   = 3'd5;
    localparam logic [2:0] S_FREQ_WAIT = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    localparam logic [pdfm_pkg::CH_W-1:0] LAST_CH = pdfm_pkg::CH_W'(pdfm_pkg::NUM_CHANNELS - 1);

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [pdfm_pkg::CH_W-1:0]   chan_reg;
    logic [pdfm_pkg::CH_W-1:0]   chan_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.chan       = chan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                chan_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.need)
                begin
                    cmd.prep_duty = 1'b1;
                    state_next    = S_DUTY_GO;
                end
                else if (chan_reg == LAST_CH)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    chan_next = chan_reg + 1'b1;
                end
            end
            S_DUTY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_steps = pdfm_pkg::DUTY_STEPS;
                state_next    = S_DUTY_WAIT;
            end
            S_DUTY_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.save_duty = 1'b1;
                    cmd.prep_freq = 1'b1;
                    state_next    = S_FREQ_GO;
                end
            end
            S_FREQ_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_steps = pdfm_pkg::FREQ_STEPS;
                state_next    = S_FREQ_WAIT;
            end
            S_FREQ_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.commit = 1'b1;
                    if (chan_reg == LAST_CH)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_DONE:
            begin
                // The previous result may still be waiting; load only once it leaves.
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `PDFM_ASSERT_IMP(a_start_when_free, cmd.div_start, !stat.div_busy,
        "divider started while still busy")
    `PDFM_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready,
        "second item accepted while one is in progress")
    `PDFM_ASSERT_IMP(a_load_free_slot, cmd.out_load, out_free,
        "result loaded over one not yet taken")

endmodule

>>> rtl/pwm_duty_frequency_meter.sv
`timescale 1ns / 1ps
// Channel   Handshake            Fields
// input     in_valid / in_ready  op, levels, read_channel
// output    out_valid/ out_ready glitch_seen, channel_ok, duty, frequency
//
// Every item scans all channels in turn; each one that completes a period is
// divided by the shared restoring divider, one quotient bit a cycle (7 for
// duty, 10 for frequency).
// One item is in progress at a time; the next is accepted while a result waits.
// Reset clears all phases, counters and stored results at once.
// A stalled output holds the finished result; the next item waits in its done state until it is taken.

module pwm_duty_frequency_meter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic [pdfm_pkg::LEVEL_W-1:0]         levels,
    input  logic [pdfm_pkg::RC_W-1:0]            read_channel,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 glitch_seen,
    output logic                                 channel_ok,
    output logic [pdfm_pkg::DUTY_W-1:0]          duty,
    output logic [pdfm_pkg::FREQ_W-1:0]          frequency
);

    pdfm_pkg::cmd_t    cmd;
    pdfm_pkg::status_t stat;

    pdfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pdfm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_op           (op),
        .in_levels       (levels),
        .in_read_channel (read_channel),
        .cmd             (cmd),
        .stat            (stat),
        .glitch_seen     (glitch_seen),
        .channel_ok      (channel_ok),
        .duty            (duty),
        .frequency       (frequency)
    );

endmodule
